### rtl/core/cbd_pkg.sv
`default_nettype none
package cbd_pkg;

  localparam int SizeBits = 32;
  localparam int TotalBits = 32;

  localparam logic [TotalBits-1:0] MaxBodyReset = TotalBits'(2000000000);

  localparam logic [7:0] CharCr = 8'h0d;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharLowA = 8'h61;
  localparam logic [7:0] CharLowF = 8'h66;
  localparam logic [3:0] HexTen = 4'd10;

  localparam logic KindPayload = 1'b0;
  localparam logic KindEnd = 1'b1;

  typedef enum logic [3:0] {
    PH_LINE = 4'b0001,
    PH_SKIP = 4'b0010,
    PH_DATA = 4'b0100,
    PH_DONE = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_body;
  } item_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] out_byte;
    logic       too_large;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.ok = 1'b0;
    h.value = 4'd0;
    if (b >= CharZero && b <= CharNine) begin
      h.ok = 1'b1;
      h.value = 4'(b - CharZero);
    end else if (b >= CharLowA && b <= CharLowF) begin
      h.ok = 1'b1;
      h.value = 4'(b - CharLowA) + HexTen;
    end
    return h;
  endfunction

endpackage
`default_nettype wire

### rtl/core/cbd_parser.sv
`default_nettype none
module cbd_parser import cbd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire item_t                item,
  input  wire logic [TotalBits-1:0] max_body_bytes,
  output logic                      has_result,
  output result_t                   result
);

  phase_t               phase, phase_next;
  logic [SizeBits-1:0]  size_accum, size_accum_next;
  logic                 line_empty, line_empty_next;
  logic                 line_first_zero, line_first_zero_next;
  logic                 line_invalid, line_invalid_next;
  logic [SizeBits-1:0]  bytes_left, bytes_left_next;
  logic [TotalBits-1:0] total_bytes, total_bytes_next;

  phase_t               cur_phase;
  logic [SizeBits-1:0]  cur_accum;
  logic                 cur_empty;
  logic                 cur_first_zero;
  logic                 cur_invalid;
  logic [SizeBits-1:0]  cur_left;
  logic [TotalBits-1:0] cur_total;
  logic [SizeBits-1:0]  line_value;
  logic [SizeBits-1:0]  left_dec;
  hex_t                 digit;

  always_comb begin
    cur_phase = phase;
    cur_accum = size_accum;
    cur_empty = line_empty;
    cur_first_zero = line_first_zero;
    cur_invalid = line_invalid;
    cur_left = bytes_left;
    cur_total = total_bytes;
    if (item.start_body) begin
      cur_phase = PH_LINE;
      cur_accum = '0;
      cur_empty = 1'b1;
      cur_first_zero = 1'b0;
      cur_invalid = 1'b0;
      cur_left = '0;
      cur_total = '0;
    end

    digit = hex_digit(item.in_byte);
    line_value = cur_invalid ? '0 : cur_accum;
    left_dec = cur_left - SizeBits'(1);

    phase_next = cur_phase;
    size_accum_next = cur_accum;
    line_empty_next = cur_empty;
    line_first_zero_next = cur_first_zero;
    line_invalid_next = cur_invalid;
    bytes_left_next = cur_left;
    total_bytes_next = cur_total;
    has_result = 1'b0;
    result = '0;

    case (cur_phase)
      PH_DONE: begin
      end
      PH_SKIP: begin
        phase_next = (cur_left != '0) ? PH_DATA : PH_LINE;
      end
      PH_DATA: begin
        bytes_left_next = left_dec;
        if (cur_total != '1) begin
          total_bytes_next = cur_total + TotalBits'(1);
        end
        if (left_dec == '0) begin
          phase_next = PH_LINE;
        end
        has_result = 1'b1;
        result.kind = KindPayload;
        result.out_byte = item.in_byte;
      end
      PH_LINE: begin
        if (item.in_byte == CharCr) begin
          size_accum_next = '0;
          line_empty_next = 1'b1;
          line_first_zero_next = 1'b0;
          line_invalid_next = 1'b0;
          if (cur_first_zero && line_value == '0) begin
            phase_next = PH_DONE;
            has_result = 1'b1;
            result.kind = KindEnd;
            result.too_large = (cur_total > max_body_bytes);
          end else begin
            bytes_left_next = line_value;
            phase_next = PH_SKIP;
          end
        end else begin
          if (cur_empty) begin
            line_first_zero_next = (item.in_byte == CharZero);
          end
          line_empty_next = 1'b0;
          if (!digit.ok) begin
            line_invalid_next = 1'b1;
          end else if (cur_accum[SizeBits-1 -: 4] != 4'd0) begin
            size_accum_next = '1;
          end else begin
            size_accum_next = {cur_accum[SizeBits-5:0], digit.value};
          end
        end
      end
      default: begin
        phase_next = PH_LINE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LINE;
      size_accum <= '0;
      line_empty <= 1'b1;
      line_first_zero <= 1'b0;
      line_invalid <= 1'b0;
      bytes_left <= '0;
      total_bytes <= '0;
    end else if (step) begin
      phase <= phase_next;
      size_accum <= size_accum_next;
      line_empty <= line_empty_next;
      line_first_zero <= line_first_zero_next;
      line_invalid <= line_invalid_next;
      bytes_left <= bytes_left_next;
      total_bytes <= total_bytes_next;
    end
  end

endmodule
`default_nettype wire

### rtl/core/chunked_body_decoder_core.sv
// Decoder for an HTTP chunked message body, one raw byte per input beat.
// Input channel: item_valid, item_stall and item (in_byte, start_body).
// A beat is taken at a rising edge with item_valid high and item_stall low.
// Output channel: result_valid, result_stall and result (kind, out_byte,
// too_large), taken when result_valid is high and result_stall is low.
// Each input beat gives zero or one output beat: a payload byte, or an end
// of body marker that carries the too large flag.
// Configuration: cfg_valid, cfg_ready and cfg_data write the maximum body
// length. cfg_ready is always high. Writes are to be made while idle;
// the block itself does not enforce this. An input beat passes through
// the input register and the parse logic into the result register.
// Throughput is one byte per cycle while item_stall is low, set by the
// single parse stage. When the receiver stalls, the result register holds
// its beat and the input register still drains bytes that give no result;
// a byte that would give one waits and item_stall rises.
// Reset clears the valid flags of both registers and all parse state, and
// sets the maximum body length to 2000000000.
`default_nettype none
module chunked_body_decoder_core import cbd_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 item_valid,
  output logic                      item_stall,
  input  wire item_t                item,
  output logic                      result_valid,
  input  wire logic                 result_stall,
  output result_t                   result,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [TotalBits-1:0] cfg_data
);

  logic [TotalBits-1:0] max_body_bytes;
  logic                 held_valid;
  item_t                held;
  logic                 step;
  logic                 has_result;
  result_t              step_result;
  logic                 out_free;

  assign cfg_ready = 1'b1;
  assign out_free = !result_valid || !result_stall;
  assign step = held_valid && (!has_result || out_free);
  assign item_stall = held_valid && !step;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_body_bytes <= MaxBodyReset;
    end else if (cfg_valid && cfg_ready) begin
      max_body_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      held_valid <= 1'b1;
    end else if (step) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      held <= item;
    end
  end

  cbd_parser u_parser (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .item           (held),
    .max_body_bytes (max_body_bytes),
    .has_result     (has_result),
    .result         (step_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step && has_result) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && has_result) begin
      result <= step_result;
    end
  end

endmodule
`default_nettype wire

### sim/chunked_body_decoder_core_test.sv
`timescale 1ns / 100ps
module chunked_body_decoder_core_test;
  import cbd_pkg::*;

  localparam logic [7:0] CharLf = 8'h0a;

  class body_scoreboard;
    result_t expected_q[$];
    int errors;
    phase_t ph;
    logic [SizeBits-1:0] size_acc;
    logic [SizeBits-1:0] bytes_left;
    logic [TotalBits-1:0] decoded_total;
    logic [TotalBits-1:0] body_limit;
    bit line_empty;
    bit first_zero;
    bit line_bad;

    function new();
      errors = 0;
      body_limit = MaxBodyReset;
      clear_parse();
    endfunction

    function void clear_line();
      size_acc = '0;
      line_empty = 1'b1;
      first_zero = 1'b0;
      line_bad = 1'b0;
    endfunction

    function void clear_parse();
      ph = PH_LINE;
      clear_line();
      bytes_left = '0;
      decoded_total = '0;
    endfunction

    function void set_limit(logic [TotalBits-1:0] v);
      body_limit = v;
    endfunction

    function void note_item(item_t it);
      result_t r;
      logic [7:0] b;
      logic [3:0] d;
      logic [SizeBits-1:0] line_value;
      bit is_digit;
      b = it.in_byte;
      if (it.start_body) clear_parse();
      case (ph)
        PH_DONE: ;
        PH_SKIP: ph = (bytes_left != 0) ? PH_DATA : PH_LINE;
        PH_DATA: begin
          bytes_left = bytes_left - 1'b1;
          if (decoded_total != '1) decoded_total = decoded_total + 1'b1;
          if (bytes_left == 0) ph = PH_LINE;
          r.kind = KindPayload;
          r.out_byte = b;
          r.too_large = 1'b0;
          expected_q = {expected_q, r};
        end
        default: begin
          if (b == CharCr) begin
            line_value = line_bad ? '0 : size_acc;
            if (first_zero && line_value == 0) begin
              ph = PH_DONE;
              r.kind = KindEnd;
              r.out_byte = 8'h00;
              r.too_large = (decoded_total > body_limit);
              expected_q = {expected_q, r};
            end else begin
              bytes_left = line_value;
              ph = PH_SKIP;
            end
            clear_line();
          end else begin
            if (line_empty) first_zero = (b == CharZero);
            line_empty = 1'b0;
            is_digit = 1'b1;
            d = 4'd0;
            if (b >= CharZero && b <= CharNine) d = 4'(b - CharZero);
            else if (b >= CharLowA && b <= CharLowF) d = 4'(b - CharLowA) + HexTen;
            else is_digit = 1'b0;
            if (!is_digit) line_bad = 1'b1;
            else if (size_acc[SizeBits-1 -: 4] != 0) size_acc = '1;
            else size_acc = {size_acc[SizeBits-5:0], d};
          end
        end
      endcase
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("unexpected beat: kind %0d out_byte 0x%02h too_large %0d",
               got.kind, got.out_byte, got.too_large);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) begin
        $error("kind: expected %0d, got %0d", want.kind, got.kind);
        errors++;
      end
      if (got.out_byte !== want.out_byte) begin
        $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
        errors++;
      end
      if (got.too_large !== want.too_large) begin
        $error("too_large: expected %0d, got %0d", want.too_large, got.too_large);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  item_t item;
  logic result_valid;
  logic result_stall;
  result_t result;
  logic cfg_valid;
  logic cfg_ready;
  logic [TotalBits-1:0] cfg_data;

  body_scoreboard sb;
  int beats_sent;
  bit body_start;
  bit use_gaps;

  chunked_body_decoder_core u_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .item(item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] hex_char(input int v);
    if (v < 10) return CharZero + 8'(v);
    return CharLowA + 8'(v - 10);
  endfunction

  task automatic send_beat(input item_t it);
    int gap;
    gap = use_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= it;
    do @(posedge clk); while (item_stall !== 1'b0);
    sb.note_item(it);
  endtask

  task automatic send_byte(input logic [7:0] b, input bit counted);
    item_t it;
    it.in_byte = b;
    it.start_body = body_start;
    body_start = 1'b0;
    if (counted) beats_sent++;
    send_beat(it);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b1);
  endtask

  task automatic end_line();
    send_byte(CharCr, 1'b1);
    send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255)) : CharLf, 1'b1);
  endtask

  task automatic send_random_body();
    int nchunks;
    int sz;
    int r;
    logic [7:0] b;
    bit dropped;
    body_start = 1'b1;
    use_gaps = ($urandom_range(0, 3) != 0);
    dropped = 1'b0;
    nchunks = $urandom_range(0, 4);
    for (int c = 0; c < nchunks && !dropped; c++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        sz = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        if ($urandom_range(0, 4) == 0) send_byte(CharZero, 1'b1);
        send_text($sformatf("%0h", sz));
        end_line();
        repeat (sz) send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else if (r < 78) begin
        repeat ($urandom_range(0, 2)) begin
          b = 8'($urandom_range(0, 255));
          if (b == CharCr) b = 8'h47;
          send_byte(b, 1'b1);
        end
        send_byte(8'h47, 1'b1);
        end_line();
      end else if (r < 84) begin
        end_line();
      end else if (r < 90) begin
        case ($urandom_range(0, 3))
          0: send_text("A");
          1: send_text("1F");
          2: send_text("Bc");
          default: send_text("FF");
        endcase
        end_line();
      end else if (r < 95) begin
        send_text("fffffffff");
        repeat ($urandom_range(0, 2)) send_byte(hex_char($urandom_range(0, 15)), 1'b1);
        end_line();
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), 1'b1);
        dropped = 1'b1;
      end else begin
        send_byte(hex_char($urandom_range(1, 15)), 1'b1);
        dropped = 1'b1;
      end
    end
    if (!dropped) begin
      r = $urandom_range(0, 9);
      case (r)
        0: ;
        1: begin
          send_text("00");
          send_byte(CharCr, 1'b1);
        end
        2: begin
          send_text("0z");
          send_byte(CharCr, 1'b1);
        end
        3: begin
          send_text("000");
          end_line();
        end
        default: begin
          send_text("0");
          end_line();
        end
      endcase
      if (r != 0 && $urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_limit(input logic [TotalBits-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  always @(posedge clk) begin
    if (!rst && result_valid === 1'b1 && !result_stall) sb.check_result(result);
  end

  initial begin
    int len;
    result_stall = 1'b0;
    @(posedge clk);
    forever begin
      len = pick_gap();
      if (len > 0) begin
        result_stall <= 1'b1;
        repeat (len) @(posedge clk);
      end
      result_stall <= 1'b0;
      repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 6))
        @(posedge clk);
    end
  end

  initial begin
    #10_000_000;
    $display("chunked_body_decoder_core_test failed");
    $finish;
  end

  initial begin
    logic [TotalBits-1:0] limits [5];
    int target;
    sb = new();
    clk = 1'b0;
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    beats_sent = 0;
    body_start = 1'b0;
    use_gaps = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    body_start = 1'b1;
    send_text("2");
    end_line();
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    end_line();
    send_text("Z");
    end_line();
    send_text("A");
    end_line();
    send_text("01");
    end_line();
    send_byte(8'h5a, 1'b1);
    send_text("0x");
    end_line();
    send_byte(8'h71, 1'b0);

    limits[0] = '0;
    limits[1] = '1;
    limits[2] = $urandom_range(0, 80);
    limits[3] = $urandom_range(0, 80);
    limits[4] = $urandom();
    target = beats_sent;
    for (int p = 0; p < 5; p++) begin
      write_limit(limits[p]);
      target += 230;
      while (beats_sent < target) send_random_body();
    end

    settle();
    if (sb.errors == 0) begin
      $display("chunked_body_decoder_core_test passed");
    end else begin
      $display("chunked_body_decoder_core_test failed");
    end
    $finish;
  end

endmodule
